// ----- rtl/core/crp_pkg.sv -----
// shared types, constants and mode decode for the capability response parser
package crp_pkg;

   localparam logic [7:0] TermByte = 8'h7F;
   localparam logic [7:0] NonePin  = 8'hFF;

   localparam logic [7:0] ModeInput  = 8'h00;
   localparam logic [7:0] ModeOutput = 8'h01;
   localparam logic [7:0] ModeAnalog = 8'h02;
   localparam logic [7:0] ModePwm    = 8'h03;
   localparam logic [7:0] ModeServo  = 8'h04;
   localparam logic [7:0] ModeI2c    = 8'h06;
   localparam logic [7:0] ModePullup = 8'h0B;

   localparam logic [2:0] CapInput  = 3'd0;
   localparam logic [2:0] CapOutput = 3'd1;
   localparam logic [2:0] CapPullup = 3'd2;
   localparam logic [2:0] CapAnalog = 3'd3;
   localparam logic [2:0] CapPwm    = 3'd4;
   localparam logic [2:0] CapServo  = 3'd5;
   localparam logic [2:0] CapI2c    = 3'd6;

   localparam logic RecordPin     = 1'b0;
   localparam logic RecordSummary = 1'b1;

   localparam int RspQueueDepth = 4;

   typedef struct packed {
      logic       record_kind;
      logic [7:0] pin_index;
      logic [6:0] caps_mask;
      logic [7:0] analog_bits;
      logic [7:0] pwm_bits;
      logic [7:0] servo_bits;
      logic [7:0] pin_total;
      logic [7:0] first_analog_pin;
      logic [7:0] analog_total;
      logic       profile_valid;
   } result_type;

   typedef struct packed {
      logic rec_valid;
      logic sum_valid;
   } emit_type;

   typedef struct packed {
      logic       known;
      logic [2:0] cap;
   } mode_type;

   function automatic mode_type mode_to_cap(input logic [7:0] code);
      mode_type m;
      m.known = 1'b1;
      case (code)
         ModeInput:  m.cap = CapInput;
         ModeOutput: m.cap = CapOutput;
         ModeAnalog: m.cap = CapAnalog;
         ModePwm:    m.cap = CapPwm;
         ModeServo:  m.cap = CapServo;
         ModeI2c:    m.cap = CapI2c;
         ModePullup: m.cap = CapPullup;
         default: begin
            m.known = 1'b0;
            m.cap   = CapInput;
         end
      endcase
      return m;
   endfunction

endpackage

// ----- rtl/core/crp_parser.sv -----
// parse state and per-byte decode, producing the pin record and summary
module crp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                last,
   output crp_pkg::emit_type   emit,
   output crp_pkg::result_type rec,
   output crp_pkg::result_type sum
);
   import crp_pkg::*;

   logic       await_value_ff, await_value_in;
   logic [2:0] pending_mode_ff, pending_mode_in;
   logic [6:0] open_caps_ff, open_caps_in;
   logic [7:0] open_analog_bits_ff, open_analog_bits_in;
   logic [7:0] open_pwm_bits_ff, open_pwm_bits_in;
   logic [7:0] open_servo_bits_ff, open_servo_bits_in;
   logic [8:0] pins_seen_ff, pins_seen_in;
   logic [7:0] analog_start_ff, analog_start_in;
   logic [8:0] analog_seen_ff, analog_seen_in;
   logic       bad_flag_ff, bad_flag_in;

   always_comb begin
      logic       av1;
      logic [2:0] pm1;
      logic [6:0] caps1;
      logic [7:0] ab1, pb1, sb1;
      logic [7:0] as1;
      logic [8:0] asn1;
      logic       bad1, bad2;
      logic       term;
      logic       do_close;
      logic [8:0] pins2;
      mode_type   m;

      av1   = await_value_ff;
      pm1   = pending_mode_ff;
      caps1 = open_caps_ff;
      ab1   = open_analog_bits_ff;
      pb1   = open_pwm_bits_ff;
      sb1   = open_servo_bits_ff;
      as1   = analog_start_ff;
      asn1  = analog_seen_ff;
      bad1  = bad_flag_ff;
      term  = 1'b0;
      m     = mode_to_cap(data_byte);

      if (await_value_ff) begin
         av1 = 1'b0;
         case (pending_mode_ff)
            CapAnalog: begin
               if (open_caps_ff[CapAnalog]) begin
                  bad1 = 1'b1;
               end else begin
                  caps1[CapAnalog] = 1'b1;
                  ab1 = data_byte;
               end
               if (analog_start_ff == NonePin) begin
                  as1 = pins_seen_ff[7:0];
               end
               if (!analog_seen_ff[8]) begin
                  asn1 = analog_seen_ff + 9'd1;
               end
            end
            CapPwm: begin
               if (!open_caps_ff[CapPwm]) begin
                  caps1[CapPwm] = 1'b1;
                  pb1 = data_byte;
               end
            end
            CapServo: begin
               if (!open_caps_ff[CapServo]) begin
                  caps1[CapServo] = 1'b1;
                  sb1 = data_byte;
               end
            end
            default: begin
               if (data_byte == 8'd1 && pending_mode_ff != 3'd7) begin
                  caps1[pending_mode_ff] = 1'b1;
               end
            end
         endcase
      end else if (data_byte == TermByte) begin
         term = 1'b1;
      end else if (m.known) begin
         pm1 = m.cap;
         av1 = 1'b1;
      end

      do_close = term || (last && !av1);
      bad2     = bad1 || (last && av1);
      pins2    = (do_close && !pins_seen_ff[8]) ? pins_seen_ff + 9'd1 : pins_seen_ff;

      emit.rec_valid = do_close;
      emit.sum_valid = last;

      rec.record_kind      = RecordPin;
      rec.pin_index        = pins_seen_ff[7:0];
      rec.caps_mask        = caps1;
      rec.analog_bits      = ab1;
      rec.pwm_bits         = pb1;
      rec.servo_bits       = sb1;
      rec.pin_total        = 8'd0;
      rec.first_analog_pin = 8'd0;
      rec.analog_total     = 8'd0;
      rec.profile_valid    = 1'b0;

      sum.record_kind      = RecordSummary;
      sum.pin_index        = 8'd0;
      sum.caps_mask        = 7'd0;
      sum.analog_bits      = 8'd0;
      sum.pwm_bits         = 8'd0;
      sum.servo_bits       = 8'd0;
      sum.pin_total        = pins2[8] ? 8'hFF : pins2[7:0];
      sum.first_analog_pin = as1;
      sum.analog_total     = asn1[8] ? 8'hFF : asn1[7:0];
      sum.profile_valid    = !bad2 && !pins2[8];

      if (last) begin
         await_value_in      = 1'b0;
         pending_mode_in     = 3'd0;
         open_caps_in        = 7'd0;
         open_analog_bits_in = 8'd0;
         open_pwm_bits_in    = 8'd0;
         open_servo_bits_in  = 8'd0;
         pins_seen_in        = 9'd0;
         analog_start_in     = NonePin;
         analog_seen_in      = 9'd0;
         bad_flag_in         = 1'b0;
      end else begin
         await_value_in      = av1;
         pending_mode_in     = pm1;
         open_caps_in        = do_close ? 7'd0 : caps1;
         open_analog_bits_in = do_close ? 8'd0 : ab1;
         open_pwm_bits_in    = do_close ? 8'd0 : pb1;
         open_servo_bits_in  = do_close ? 8'd0 : sb1;
         pins_seen_in        = pins2;
         analog_start_in     = as1;
         analog_seen_in      = asn1;
         bad_flag_in         = bad1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         await_value_ff      <= 1'b0;
         pending_mode_ff     <= 3'd0;
         open_caps_ff        <= 7'd0;
         open_analog_bits_ff <= 8'd0;
         open_pwm_bits_ff    <= 8'd0;
         open_servo_bits_ff  <= 8'd0;
         pins_seen_ff        <= 9'd0;
         analog_start_ff     <= NonePin;
         analog_seen_ff      <= 9'd0;
         bad_flag_ff         <= 1'b0;
      end else if (accept) begin
         await_value_ff      <= await_value_in;
         pending_mode_ff     <= pending_mode_in;
         open_caps_ff        <= open_caps_in;
         open_analog_bits_ff <= open_analog_bits_in;
         open_pwm_bits_ff    <= open_pwm_bits_in;
         open_servo_bits_ff  <= open_servo_bits_in;
         pins_seen_ff        <= pins_seen_in;
         analog_start_ff     <= analog_start_in;
         analog_seen_ff      <= analog_seen_in;
         bad_flag_ff         <= bad_flag_in;
      end
   end

endmodule

// ----- rtl/core/crp_rsp_queue.sv -----
// result queue taking up to two results per cycle and releasing one per cycle while rsp_ready is high
module crp_rsp_queue #(
   parameter int Depth = crp_pkg::RspQueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  crp_pkg::emit_type   emit,
   input  crp_pkg::result_type rec,
   input  crp_pkg::result_type sum,
   output logic                space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output crp_pkg::result_type rsp_data
);
   import crp_pkg::*;

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   result_type            slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   logic                  push_a, push_b, pop;
   result_type            entry_a;
   logic [PtrWidth-1:0]   wr_next;
   logic [CountWidth-1:0] n_push;

   assign push_a  = push && (emit.rec_valid || emit.sum_valid);
   assign push_b  = push && emit.rec_valid && emit.sum_valid;
   assign entry_a = emit.rec_valid ? rec : sum;
   assign wr_next = wr_ptr_ff + PtrWidth'(1);
   assign n_push  = CountWidth'(push_a) + CountWidth'(push_b);

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign space     = (count_ff <= CountWidth'(Depth - 2));

   assign wr_ptr_in = wr_ptr_ff + PtrWidth'(n_push);
   assign rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
   assign count_in  = count_ff + n_push - CountWidth'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         slot_ff[wr_ptr_ff] <= entry_a;
      end
      if (push_b) begin
         slot_ff[wr_next] <= sum;
      end
   end

endmodule

// ----- rtl/core/pin_capability_response_parser.sv -----
// top level of the pin capability response parser
//
// request channel: one raw response byte per request on req_data_byte, with
// req_last high on the final byte of a response. the result channel carries
// one record per beat: a per-pin record (rsp_record_kind 0) when a pin list
// closes, and a summary (rsp_record_kind 1) after the last byte.
// a request is decoded in the cycle it is accepted and its results are
// registered in an output queue, from which the rsp_ side offers them in
// order; when the last byte closes a pin, the pin record comes first and
// the summary follows it.
// throughput is one request per cycle while req_ready is high; the queue
// takes a request only while it has room for two results, so a request that
// yields two results takes two reads, and the rate is set by the single read
// port of the queue when every byte closes a pin and ends a response.
// synchronous reset returns the parser to the start of a response and empties
// the queue. while the receiver holds rsp_ready low, results collect in the
// queue and req_ready falls once fewer than two slots remain free.
module pin_capability_response_parser #(
   parameter int RspDepth = crp_pkg::RspQueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_record_kind,
   output logic [7:0] rsp_pin_index,
   output logic [6:0] rsp_caps_mask,
   output logic [7:0] rsp_analog_bits,
   output logic [7:0] rsp_pwm_bits,
   output logic [7:0] rsp_servo_bits,
   output logic [7:0] rsp_pin_total,
   output logic [7:0] rsp_first_analog_pin,
   output logic [7:0] rsp_analog_total,
   output logic       rsp_profile_valid
);
   import crp_pkg::*;

   logic       accept;
   logic       space;
   emit_type   emit;
   result_type rec, sum, rsp_data;

   assign req_ready = space;
   assign accept    = req_valid && space;

   crp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last      (req_last),
      .emit      (emit),
      .rec       (rec),
      .sum       (sum)
   );

   crp_rsp_queue #(
      .Depth (RspDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .emit      (emit),
      .rec       (rec),
      .sum       (sum),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_record_kind      = rsp_data.record_kind;
   assign rsp_pin_index        = rsp_data.pin_index;
   assign rsp_caps_mask        = rsp_data.caps_mask;
   assign rsp_analog_bits      = rsp_data.analog_bits;
   assign rsp_pwm_bits         = rsp_data.pwm_bits;
   assign rsp_servo_bits       = rsp_data.servo_bits;
   assign rsp_pin_total        = rsp_data.pin_total;
   assign rsp_first_analog_pin = rsp_data.first_analog_pin;
   assign rsp_analog_total     = rsp_data.analog_total;
   assign rsp_profile_valid    = rsp_data.profile_valid;

endmodule
